// ===== rtl/tsld_pkg.sv =====
// shared types and constants for the two-axis slew-limited drive
// no dependencies; imported by tsld_axis and the top level
`default_nettype none

package tsld_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LIM_W     = 31;
  localparam int unsigned TICK_W    = 24;
  localparam int unsigned TICK_FRAC = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned DIV_STEPS = 32;

  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1677722);

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT_A  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT_B  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT_B = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD   = CFG_IDX_W'(4);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CLAMP,
    ST_DIFF,
    ST_STEP,
    ST_APPLY,
    ST_PREP,
    ST_RUN
  } tsld_state_e;

  typedef struct packed {
    tsld_state_e phase;
    logic        start;
    logic        mul_en;
    logic        commit;
  } tsld_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/tsld_axis.sv =====
// one axis: rate clamp, slew limit, bit-serial multiplier and divider, axis state
// depends on tsld_pkg; sequenced by the top level through tsld_ctrl_t
`default_nettype none

module tsld_axis (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  tsld_pkg::tsld_ctrl_t                   ctrl_i,
  input  logic signed [tsld_pkg::DATA_W-1:0]     cmd_i,
  input  logic        [tsld_pkg::LIM_W-1:0]      rate_limit_i,
  input  logic        [tsld_pkg::LIM_W-1:0]      accel_limit_i,
  input  logic        [tsld_pkg::TICK_W-1:0]     tick_i,
  input  logic                                   fin_i,
  output logic signed [tsld_pkg::DATA_W-1:0]     angle_o,
  output logic signed [tsld_pkg::DATA_W-1:0]     velocity_o,
  output logic signed [tsld_pkg::DATA_W-1:0]     accel_o
);
  import tsld_pkg::*;

  localparam int unsigned HI_W  = DATA_W + 1;
  localparam int unsigned ACC_W = HI_W + TICK_W;
  localparam int unsigned SUM_W = DATA_W + 2;
  localparam int unsigned SH_W  = DATA_W - TICK_FRAC;

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic signed [DATA_W-1:0] cmd_q, target_q, new_vel_q;
  logic signed [HI_W-1:0]   diff_q, applied_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic                     neg_q, div_sat_q;
  logic [TICK_W-1:0]        rem_q;
  logic [DATA_W-1:0]        dvd_q, quo_q;
  logic [ACC_W-1:0]         acc_q;
  logic signed [DATA_W-1:0] vel_q, angle_q, accel_q;

  logic signed [HI_W-1:0]   rl_s, cmd_x, lim_s, inc_c, applied_c, mcand, hi, sum_m;
  logic signed [DATA_W-1:0] target_c, nv_c, accel_c;
  logic signed [SUM_W-1:0]  sum_c;
  logic [HI_W-1:0]          mag_c;
  logic                     div_sat_c, ge;
  logic [TICK_W:0]          trial;
  logic [TICK_W-1:0]        rem_next;
  logic [ACC_W-1:0]         acc_next;

  // rate clamp
  always_comb begin
    rl_s  = signed'({2'b00, rate_limit_i});
    cmd_x = {cmd_q[DATA_W-1], cmd_q};
    if (cmd_x > rl_s) begin
      target_c = rl_s[DATA_W-1:0];
    end else if (cmd_x < -rl_s) begin
      target_c = DATA_W'(-rl_s);
    end else begin
      target_c = cmd_q;
    end
  end

  // slew clamp and velocity update
  always_comb begin
    lim_s = signed'({2'b00, acc_q[TICK_FRAC+LIM_W-1:TICK_FRAC]});
    if (diff_q > lim_s) begin
      inc_c = lim_s;
    end else if (diff_q < -lim_s) begin
      inc_c = -lim_s;
    end else begin
      inc_c = diff_q;
    end
    sum_c = {{2{vel_q[DATA_W-1]}}, vel_q} + {inc_c[HI_W-1], inc_c};
    if (sum_q[SUM_W-1:DATA_W-1] != {3{sum_q[SUM_W-1]}}) begin
      nv_c = sum_q[SUM_W-1] ? S_MIN : S_MAX;
    end else begin
      nv_c = sum_q[DATA_W-1:0];
    end
    applied_c = {nv_c[DATA_W-1], nv_c} - {vel_q[DATA_W-1], vel_q};
    mag_c     = applied_q[HI_W-1] ? HI_W'(-applied_q) : HI_W'(applied_q);
    div_sat_c = mag_c >= {1'b0, tick_i, {SH_W{1'b0}}};
  end

  // shift-add multiplier, one multiplier bit per cycle
  always_comb begin
    hi = signed'(acc_q[ACC_W-1:TICK_W]);
    if (ctrl_i.phase == ST_MUL) begin
      mcand = signed'({2'b00, accel_limit_i});
    end else begin
      mcand = {new_vel_q[DATA_W-1], new_vel_q};
    end
    sum_m    = hi + (acc_q[0] ? mcand : '0);
    acc_next = {sum_m[HI_W-1], sum_m, acc_q[TICK_W-1:1]};
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    trial    = {rem_q, dvd_q[DATA_W-1]};
    ge       = trial >= {1'b0, tick_i};
    rem_next = ge ? TICK_W'(trial - {1'b0, tick_i}) : trial[TICK_W-1:0];
  end

  // acceleration saturation
  always_comb begin
    if (div_sat_q) begin
      accel_c = neg_q ? S_MIN : S_MAX;
    end else if (!neg_q) begin
      accel_c = quo_q[DATA_W-1] ? S_MAX : signed'(quo_q);
    end else begin
      accel_c = quo_q[DATA_W-1] ? S_MIN : signed'(DATA_W'(-quo_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      cmd_q <= cmd_i;
      acc_q <= {{HI_W{1'b0}}, tick_i};
    end
    unique case (ctrl_i.phase)
      ST_CLAMP: begin
        target_q <= target_c;
      end
      ST_DIFF: begin
        diff_q <= {target_q[DATA_W-1], target_q} - {vel_q[DATA_W-1], vel_q};
      end
      ST_STEP: begin
        sum_q <= sum_c;
      end
      ST_APPLY: begin
        new_vel_q <= nv_c;
        applied_q <= applied_c;
      end
      ST_PREP: begin
        neg_q     <= applied_q[HI_W-1];
        div_sat_q <= div_sat_c;
        rem_q     <= mag_c[DATA_W-1:SH_W];
        dvd_q     <= {mag_c[SH_W-1:0], {TICK_FRAC{1'b0}}};
        quo_q     <= '0;
        acc_q     <= {{HI_W{1'b0}}, tick_i};
      end
      ST_RUN: begin
        rem_q <= rem_next;
        dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
        quo_q <= {quo_q[DATA_W-2:0], ge};
      end
      default: begin
      end
    endcase
    if (ctrl_i.mul_en) begin
      acc_q <= acc_next;
    end
  end

  // axis state, updated when the result is handed over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q   <= '0;
      angle_q <= '0;
      accel_q <= '0;
    end else if (ctrl_i.commit && fin_i) begin
      vel_q   <= new_vel_q;
      angle_q <= angle_q + signed'(acc_q[TICK_FRAC+DATA_W-1:TICK_FRAC]);
      accel_q <= accel_c;
    end
  end

  assign angle_o    = angle_q;
  assign velocity_o = vel_q;
  assign accel_o    = accel_q;

endmodule

`default_nettype wire

// ===== rtl/two_axis_slew_limited_drive_top.sv =====
// top level of the two-axis slew-limited drive: handshakes, registers, sequencer
// depends on tsld_pkg and tsld_axis
//
// Each transaction carries the commanded rates of both axes; both axes are worked
// in parallel by their own bit-serial units and one result follows each command.
// A transaction runs the shift-add multiplier that forms the slew limit, the clamp,
// diff, step, apply and prep states for clamping and velocity update, and then the
// restoring divider for the acceleration, with the angle multiplier running beside
// it. A hand-over step follows; no new command is accepted until the block is idle.
// The result is held in the axis state registers until taken; a finished command
// waits in the hand-over step while the previous result is still stalled.
// Configuration must be written only while idle; the block does not enforce it.
`default_nettype none

module two_axis_slew_limited_drive_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tsld_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [tsld_pkg::LIM_W-1:0]            cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [tsld_pkg::DATA_W-1:0]    cmd_rate_a_i,
  input  logic signed [tsld_pkg::DATA_W-1:0]    cmd_rate_b_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [tsld_pkg::DATA_W-1:0]    angle_a_o,
  output logic signed [tsld_pkg::DATA_W-1:0]    angle_b_o,
  output logic signed [tsld_pkg::DATA_W-1:0]    velocity_a_o,
  output logic signed [tsld_pkg::DATA_W-1:0]    velocity_b_o,
  output logic signed [tsld_pkg::DATA_W-1:0]    accel_a_o,
  output logic signed [tsld_pkg::DATA_W-1:0]    accel_b_o
);
  import tsld_pkg::*;

  logic [LIM_W-1:0]  rate_limit_a_q, rate_limit_b_q, accel_limit_a_q, accel_limit_b_q;
  logic [TICK_W-1:0] tick_q;

  tsld_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              fin;
  tsld_ctrl_t        ctrl;
  tsld_ctrl_t        axis_ctrl;

  // configuration registers; a zero tick period is stored as one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_limit_a_q  <= '0;
      rate_limit_b_q  <= '0;
      accel_limit_a_q <= '0;
      accel_limit_b_q <= '0;
      tick_q          <= TICK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RATE_LIMIT_A:  rate_limit_a_q  <= cfg_data_i;
        CFG_RATE_LIMIT_B:  rate_limit_b_q  <= cfg_data_i;
        CFG_ACCEL_LIMIT_A: accel_limit_a_q <= cfg_data_i;
        CFG_ACCEL_LIMIT_B: accel_limit_b_q <= cfg_data_i;
        CFG_TICK_PERIOD: begin
          tick_q <= (cfg_data_i[TICK_W-1:0] == '0) ? TICK_W'(1) : cfg_data_i[TICK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // sequencer; a hand-over step follows the last divider step and holds while the previous result is stalled
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ctrl.phase  = state_q;
    ctrl.start  = 1'b0;
    ctrl.mul_en = 1'b0;
    ctrl.commit = 1'b0;
    fin         = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctrl.start = 1'b1;
          cnt_d      = '0;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        ctrl.mul_en = 1'b1;
        cnt_d       = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(TICK_W - 1)) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_STEP;
      ST_STEP:  state_d = ST_APPLY;
      ST_APPLY: state_d = ST_PREP;
      ST_PREP: begin
        cnt_d   = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        ctrl.mul_en = cnt_q < CNT_W'(TICK_W);
        if (cnt_q == CNT_W'(DIV_STEPS)) begin
          fin = 1'b1;
          if (!out_valid_q || !out_stall_i) begin
            ctrl.commit = 1'b1;
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign axis_ctrl = fin ? tsld_ctrl_t'{phase: ST_IDLE, start: 1'b0, mul_en: 1'b0,
                                        commit: ctrl.commit}
                         : ctrl;

  tsld_axis u_axis_a (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (axis_ctrl),
    .cmd_i         (cmd_rate_a_i),
    .rate_limit_i  (rate_limit_a_q),
    .accel_limit_i (accel_limit_a_q),
    .tick_i        (tick_q),
    .fin_i         (fin),
    .angle_o       (angle_a_o),
    .velocity_o    (velocity_a_o),
    .accel_o       (accel_a_o)
  );

  tsld_axis u_axis_b (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (axis_ctrl),
    .cmd_i         (cmd_rate_b_i),
    .rate_limit_i  (rate_limit_b_q),
    .accel_limit_i (accel_limit_b_q),
    .tick_i        (tick_q),
    .fin_i         (fin),
    .angle_o       (angle_b_o),
    .velocity_o    (velocity_b_o),
    .accel_o       (accel_b_o)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_MUL && cnt_q == '0)
    else $error("accepted transaction did not start the multiplier");

  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.commit))
    else $error("result raised without a hand-over");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> cnt_q < CNT_W'(TICK_W))
    else $error("multiplier step count out of range");

  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> cnt_q <= CNT_W'(DIV_STEPS))
    else $error("divider step count out of range");

endmodule

`default_nettype wire
